// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on aclk, reset by aresetn.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Antecedent at one edge implies consequent at the same edge.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ucfd_pkg.sv =====
// ---------------------------------------------------------------------------
// ucfd_pkg
// Constants and helpers for the serial-to-CAN frame deframer.
// ---------------------------------------------------------------------------
package ucfd_pkg;

    localparam int MAX_DATA_BYTES = 8;
    localparam int CAN_DATA_BYTES = 8;
    localparam int ID_W           = 11;
    localparam int LEN_W          = 4;
    localparam int CNT_W          = 4;
    localparam int IDX_W          = $clog2(CAN_DATA_BYTES);

    localparam int DATA_CAP_INT =
        (MAX_DATA_BYTES > CAN_DATA_BYTES) ? CAN_DATA_BYTES :
        (MAX_DATA_BYTES < 1) ? 1 : MAX_DATA_BYTES;
    localparam logic [LEN_W-1:0] DATA_CAP = LEN_W'(DATA_CAP_INT);

    typedef logic [7:0]       byte_t;
    typedef logic [ID_W-1:0]  frame_id_t;
    typedef logic [LEN_W-1:0] len_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Number of data bytes collected for a given raw length code.
    function automatic len_t frame_limit(input len_t len);
        frame_limit = (len > DATA_CAP) ? DATA_CAP : len;
    endfunction

endpackage

// ===== hw/rtl/uart_can_frame_deframer_unit.sv =====
// ---------------------------------------------------------------------------
// uart_can_frame_deframer_unit
// Rebuilds standard CAN frames from a byte stream with a start-byte framing.
// ---------------------------------------------------------------------------
// Takes one serial byte per transfer and sustains one byte per clock unless a
// finished frame is stalled. A byte is captured in an input register, then
// decoded against the frame state, and a completed frame lands in the result
// register, so m_valid rises once its last byte has passed through both
// registers. The input register holds only while a finished frame waits in
// the result register and m_ready is low. The frame
// starts at a byte equal to start_marker while hunting, followed by identifier
// bits 10..3, then a byte with identifier bits 2..0, the remote bit and a
// 4-bit length code; up to 8 data bytes follow. Remote and zero-length frames
// are emitted on the second header byte. Bytes not received read as zero.
`include "assert_macros.svh"

module uart_can_frame_deframer_unit
    import ucfd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,

    input  logic      cfg_we,
    input  logic [7:0] cfg_wdata,

    input  logic      s_valid,
    output logic      s_ready,
    input  logic [7:0] s_rx_byte,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [10:0] m_frame_id,
    output logic       m_remote_request,
    output logic [3:0] m_data_length,
    output logic [7:0] m_data_byte0,
    output logic [7:0] m_data_byte1,
    output logic [7:0] m_data_byte2,
    output logic [7:0] m_data_byte3,
    output logic [7:0] m_data_byte4,
    output logic [7:0] m_data_byte5,
    output logic [7:0] m_data_byte6,
    output logic [7:0] m_data_byte7
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_IDH,
        PH_IDL,
        PH_DATA
    } phase_t;

    byte_t     start_marker_reg;

    logic      in_valid_reg, in_valid_next;
    byte_t     in_byte_reg, in_byte_next;

    phase_t    phase_reg, phase_next;
    cnt_t      cnt_reg, cnt_next;
    frame_id_t id_reg, id_next;
    logic      rtr_reg, rtr_next;
    len_t      len_reg, len_next;
    byte_t     payload_reg [CAN_DATA_BYTES];
    byte_t     payload_next [CAN_DATA_BYTES];

    logic      out_valid_reg, out_valid_next;
    frame_id_t out_id_reg;
    logic      out_rtr_reg;
    len_t      out_len_reg;
    byte_t     out_data_reg [CAN_DATA_BYTES];

    logic      s_xfer;
    logic      advance;
    logic      emit;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_xfer  = s_valid && s_ready;

    always_comb begin
        in_byte_next  = s_xfer ? s_rx_byte : in_byte_reg;
        in_valid_next = s_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        id_next      = id_reg;
        rtr_next     = rtr_reg;
        len_next     = len_reg;
        payload_next = payload_reg;
        emit         = 1'b0;

        if (advance) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (in_byte_reg == start_marker_reg) begin
                        id_next    = '0;
                        rtr_next   = 1'b0;
                        len_next   = '0;
                        cnt_next   = '0;
                        for (int i = 0; i < CAN_DATA_BYTES; i++) begin
                            payload_next[i] = '0;
                        end
                        phase_next = PH_IDH;
                    end
                end
                PH_IDH: begin
                    id_next    = {in_byte_reg, 3'b000};
                    phase_next = PH_IDL;
                end
                PH_IDL: begin
                    id_next  = {id_reg[ID_W-1:3], in_byte_reg[7:5]};
                    rtr_next = in_byte_reg[4];
                    len_next = in_byte_reg[3:0];
                    cnt_next = '0;
                    if (in_byte_reg[4] || (frame_limit(in_byte_reg[3:0]) == '0)) begin
                        emit       = 1'b1;
                        phase_next = PH_HUNT;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA: begin
                    payload_next[cnt_reg[IDX_W-1:0]] = in_byte_reg;
                    cnt_next = cnt_reg + cnt_t'(1);
                    if (cnt_next >= frame_limit(len_reg)) begin
                        emit       = 1'b1;
                        phase_next = PH_HUNT;
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        out_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg <= '0;
            in_valid_reg     <= 1'b0;
            phase_reg        <= PH_HUNT;
            cnt_reg          <= '0;
            id_reg           <= '0;
            rtr_reg          <= 1'b0;
            len_reg          <= '0;
            for (int i = 0; i < CAN_DATA_BYTES; i++) begin
                payload_reg[i] <= '0;
            end
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                start_marker_reg <= cfg_wdata;
            end
            in_valid_reg  <= in_valid_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            id_reg        <= id_next;
            rtr_reg       <= rtr_next;
            len_reg       <= len_next;
            payload_reg   <= payload_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        if (emit) begin
            out_id_reg   <= id_next;
            out_rtr_reg  <= rtr_next;
            out_len_reg  <= len_next;
            out_data_reg <= payload_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_frame_id       = out_id_reg;
    assign m_remote_request = out_rtr_reg;
    assign m_data_length    = out_len_reg;
    assign m_data_byte0     = out_data_reg[0];
    assign m_data_byte1     = out_data_reg[1];
    assign m_data_byte2     = out_data_reg[2];
    assign m_data_byte3     = out_data_reg[3];
    assign m_data_byte4     = out_data_reg[4];
    assign m_data_byte5     = out_data_reg[5];
    assign m_data_byte6     = out_data_reg[6];
    assign m_data_byte7     = out_data_reg[7];

    // A new frame only appears after a byte was decoded in the prior cycle.
    `ASSERT_IMPLY(a_frame_from_decode, $rose(out_valid_reg), $past(advance),
        "result appeared without a decoded byte")
    // Data collection only runs for data frames with a nonzero length.
    `ASSERT_IMPLY(a_data_phase_ok, phase_reg == PH_DATA,
        !rtr_reg && (cnt_reg < frame_limit(len_reg)),
        "data phase entered with bad frame state")
    // An empty input register always takes the next byte.
    `ASSERT_IMPLY(a_ready_when_empty, !in_valid_reg, s_ready,
        "input register empty but not ready")
    // A pending frame is never overwritten before it is taken.
    `ASSERT_IMPLY(a_no_overwrite, out_valid_reg && !m_ready, !emit,
        "frame emitted over a stalled result")

endmodule
